// File: rtl/core/ugi_pkg.sv
// shared types and constants of the uniform grid interpolator
package ugi_pkg;

	// opcodes of a command word
	localparam logic [2:0] OP_WR_VAL = 3'd0;
	localparam logic [2:0] OP_WR_XX  = 3'd1;
	localparam logic [2:0] OP_WR_YY  = 3'd2;
	localparam logic [2:0] OP_LIN    = 3'd3;
	localparam logic [2:0] OP_QUAD   = 3'd4;

	// configuration register indexes
	localparam logic [2:0] CFG_ORIGIN_X   = 3'd0;
	localparam logic [2:0] CFG_ORIGIN_Y   = 3'd1;
	localparam logic [2:0] CFG_INV_STEP_X = 3'd2;
	localparam logic [2:0] CFG_INV_STEP_Y = 3'd3;
	localparam logic [2:0] CFG_HALF_SQ_X  = 3'd4;
	localparam logic [2:0] CFG_HALF_SQ_Y  = 3'd5;
	localparam logic [2:0] CFG_CELLS_X    = 3'd6;
	localparam logic [2:0] CFG_CELLS_Y    = 3'd7;

	// width of a computed node address before the range check
	localparam int unsigned QAW = 25;

	// fraction value of one, Q1.16
	localparam logic [16:0] FRAC_ONE = 17'h10000;

	typedef struct packed {
		logic [2:0]         opcode;
		logic [11:0]        node_index;
		logic signed [31:0] node_value;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] interp_value;
		logic               outside_grid;
		logic               saturated;
	} res_t;

	typedef struct packed {
		logic        outside;
		logic [11:0] cidx;
		logic [16:0] frac;
	} loc_t;

endpackage

// File: rtl/core/uniform_grid_interpolator_core.sv
// top level of the uniform grid interpolator
//
// usage
// - command channel: a word on cmd is taken at a clock edge where start is high
//   and busy is low. opcodes 0..2 write one node of the value, xx or yy table,
//   3 runs a linear query, 4 a quadratic query; codes 5..7 are dropped
// - table writes finish at the accepting edge; busy stays low and no result
//   word is produced
// - a query raises busy for its whole run; done is high for exactly one cycle
//   to mark its result word, which stays on result until the next query; the
//   receiver has no way to stall it. a query runs the locate steps, four corner
//   reads through the single read port of each table ram and the rounding steps;
//   a point off the grid returns after the locate steps
// - a new command can be taken in the cycle that done is high
// - config channel: cfg_ready is always high; registers must only change while
//   no query is running
// - reset clears control state and loads the default config; table contents
//   are undefined until written, and no clearing pass is run
module uniform_grid_interpolator_core
	import ugi_pkg::*;
#(
	parameter int unsigned NODE_DEPTH = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  cmd_t        cmd,
	output logic        done,
	output res_t        result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int unsigned AW = $clog2(NODE_DEPTH);

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_DIFF = 9'b000000010,
		ST_MUL  = 9'b000000100,
		ST_CELL = 9'b000001000,
		ST_ADDR = 9'b000010000,
		ST_READ = 9'b000100000,
		ST_RND  = 9'b001000000,
		ST_QMUL = 9'b010000000,
		ST_FIN  = 9'b100000000
	} state_t;

	state_t state_q;

	// config registers
	logic signed [31:0] origin_x_q, origin_y_q;
	logic [31:0]        inv_step_x_q, inv_step_y_q, half_sq_x_q, half_sq_y_q;
	logic [11:0]        cells_x_q, cells_y_q;

	// query datapath
	logic [2:0]         op_q;
	logic signed [31:0] px_q, py_q;
	logic signed [32:0] dx_q, dy_q;
	logic [63:0]        prodx_q, prody_q;
	logic               negx_q, negy_q;
	logic [11:0]        ci_q, cj_q;
	logic [16:0]        fx_q, fy_q;
	logic [QAW-1:0]     addr0_q;
	logic [12:0]        row_q;
	logic [32:0]        w_q [4];
	logic [31:0]        fxgx_q, fygy_q;
	logic [2:0]         cnt_q;
	logic               vld_q;
	logic [1:0]         widx_q;
	logic signed [65:0] acc_v_q, acc_xx_q, acc_yy_q;
	logic [30:0]        cx_q, cy_q;
	logic signed [31:0] f_q, fxx_q, fyy_q;
	logic signed [63:0] pxx_q, pyy_q;
	logic               done_q;
	res_t               result_q;

	// maps a scaled offset to cell and fraction, upper edge clamped to the last cell
	function automatic loc_t locate(input logic neg, input logic [63:0] prod,
	                                input logic [11:0] cells);
		loc_t        l;
		logic [63:0] lim;
		lim = {20'd0, cells, 32'd0};
		l.outside = neg || (cells == 12'd0) || (prod > lim);
		if (prod == lim) begin
			l.cidx = cells - 12'd1;
			l.frac = FRAC_ONE;
		end else begin
			l.cidx = prod[43:32];
			l.frac = {1'b0, prod[31:16]};
		end
		return l;
	endfunction

	// round half up from Q17.48 sum to Q16.16
	function automatic logic signed [31:0] rnd32(input logic signed [65:0] s);
		logic signed [65:0] t;
		t = s + 66'sh80000000;
		return t[63:32];
	endfunction

	// command accept and table write decode
	logic           cmd_acc;
	logic [QAW-1:0] widx_full;
	logic           wr_ok;
	logic           we_v, we_xx, we_yy;
	logic [AW-1:0]  waddr;

	assign cmd_acc   = start && !busy;
	assign widx_full = QAW'(cmd.node_index);
	assign wr_ok     = cmd_acc && (widx_full < QAW'(NODE_DEPTH));
	assign we_v      = wr_ok && (cmd.opcode == OP_WR_VAL);
	assign we_xx     = wr_ok && (cmd.opcode == OP_WR_XX);
	assign we_yy     = wr_ok && (cmd.opcode == OP_WR_YY);
	assign waddr     = widx_full[AW-1:0];

	// corner address for the current read slot
	logic [QAW-1:0] off, raddr_full;
	logic           rd_ok;
	logic [AW-1:0]  raddr;
	logic [31:0]    rd_v, rd_xx, rd_yy;

	always_comb begin
		unique case (cnt_q[1:0])
			2'd0:    off = '0;
			2'd1:    off = QAW'(1);
			2'd2:    off = QAW'(row_q);
			default: off = QAW'(row_q) + QAW'(1);
		endcase
	end

	assign raddr_full = addr0_q + off;
	assign rd_ok      = raddr_full < QAW'(NODE_DEPTH);
	assign raddr      = raddr_full[AW-1:0];

	ugi_ram #(.W(32), .D(NODE_DEPTH)) u_val_ram (
		.clk(clk), .we(we_v), .waddr(waddr), .wdata(cmd.node_value),
		.raddr(raddr), .rdata(rd_v)
	);

	ugi_ram #(.W(32), .D(NODE_DEPTH)) u_xx_ram (
		.clk(clk), .we(we_xx), .waddr(waddr), .wdata(cmd.node_value),
		.raddr(raddr), .rdata(rd_xx)
	);

	ugi_ram #(.W(32), .D(NODE_DEPTH)) u_yy_ram (
		.clk(clk), .we(we_yy), .waddr(waddr), .wdata(cmd.node_value),
		.raddr(raddr), .rdata(rd_yy)
	);

	// locate results
	loc_t lx, ly;
	assign lx = locate(negx_q, prodx_q, cells_x_q);
	assign ly = locate(negy_q, prody_q, cells_y_q);

	// weights and cell products
	logic [16:0]    gx, gy;
	logic [12:0]    row;
	logic [QAW-1:0] base;

	assign gx   = FRAC_ONE - fx_q;
	assign gy   = FRAC_ONE - fy_q;
	assign row  = 13'(cells_x_q) + 13'd1;
	assign base = QAW'(QAW'(cj_q) * QAW'(row)) + QAW'(ci_q);

	// corner terms, out of range nodes read as zero
	logic signed [31:0] sv, sxx, syy;
	logic signed [65:0] tv, txx, tyy;
	logic signed [33:0] wsel;

	assign sv   = vld_q ? $signed(rd_v)  : 32'sd0;
	assign sxx  = vld_q ? $signed(rd_xx) : 32'sd0;
	assign syy  = vld_q ? $signed(rd_yy) : 32'sd0;
	assign wsel = $signed({1'b0, w_q[widx_q]});
	assign tv   = wsel * sv;
	assign txx  = wsel * sxx;
	assign tyy  = wsel * syy;

	// final quadratic combine
	logic signed [65:0] tot, tr;
	logic signed [31:0] fin_val;
	logic               fin_sat;
	logic signed [31:0] f_now;

	assign f_now = rnd32(acc_v_q);
	assign tot   = (66'(f_q) <<< 16) - (66'(pxx_q) + 66'(pyy_q));
	assign tr    = (tot + 66'sd32768) >>> 16;

	always_comb begin
		if (tr > 66'sd2147483647) begin
			fin_val = 32'sh7fffffff;
			fin_sat = 1'b1;
		end else if (tr < -66'sd2147483648) begin
			fin_val = 32'sh80000000;
			fin_sat = 1'b1;
		end else begin
			fin_val = tr[31:0];
			fin_sat = 1'b0;
		end
	end

	// result strobe: off grid after locate, linear after rounding, quadratic at the end
	logic done_nxt;

	assign done_nxt = ((state_q == ST_CELL) && (lx.outside || ly.outside)) ||
	                  ((state_q == ST_RND) && (op_q == OP_LIN)) ||
	                  (state_q == ST_FIN);

	// config port
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q   <= '0;
			origin_y_q   <= '0;
			inv_step_x_q <= 32'd65536;
			inv_step_y_q <= 32'd65536;
			half_sq_x_q  <= 32'd32768;
			half_sq_y_q  <= 32'd32768;
			cells_x_q    <= 12'd63;
			cells_y_q    <= 12'd63;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_ORIGIN_X:   origin_x_q   <= $signed(cfg_data);
				CFG_ORIGIN_Y:   origin_y_q   <= $signed(cfg_data);
				CFG_INV_STEP_X: inv_step_x_q <= cfg_data;
				CFG_INV_STEP_Y: inv_step_y_q <= cfg_data;
				CFG_HALF_SQ_X:  half_sq_x_q  <= cfg_data;
				CFG_HALF_SQ_Y:  half_sq_y_q  <= cfg_data;
				CFG_CELLS_X:    cells_x_q    <= cfg_data[11:0];
				default:        cells_y_q    <= cfg_data[11:0];
			endcase
		end
	end

	// control: state, read counter, result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= done_nxt;
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_acc && (cmd.opcode == OP_LIN || cmd.opcode == OP_QUAD)) begin
						state_q <= ST_DIFF;
					end
				end
				ST_DIFF: state_q <= ST_MUL;
				ST_MUL:  state_q <= ST_CELL;
				ST_CELL: begin
					if (lx.outside || ly.outside) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_ADDR;
					end
				end
				ST_ADDR: begin
					cnt_q   <= '0;
					state_q <= ST_READ;
				end
				ST_READ: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd4) begin
						state_q <= ST_RND;
					end
				end
				ST_RND: begin
					if (op_q == OP_LIN) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_QMUL;
					end
				end
				ST_QMUL: state_q <= ST_FIN;
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			op_q <= cmd.opcode;
			px_q <= cmd.point_x;
			py_q <= cmd.point_y;
		end
		if (state_q == ST_DIFF) begin
			dx_q <= 33'(px_q) - 33'(origin_x_q);
			dy_q <= 33'(py_q) - 33'(origin_y_q);
		end
		if (state_q == ST_MUL) begin
			negx_q  <= dx_q[32];
			negy_q  <= dy_q[32];
			prodx_q <= 64'(dx_q[31:0]) * 64'(inv_step_x_q);
			prody_q <= 64'(dy_q[31:0]) * 64'(inv_step_y_q);
		end
		if (state_q == ST_CELL) begin
			ci_q <= lx.cidx;
			cj_q <= ly.cidx;
			fx_q <= lx.frac;
			fy_q <= ly.frac;
			result_q.interp_value <= '0;
			result_q.outside_grid <= 1'b1;
			result_q.saturated    <= 1'b0;
		end
		if (state_q == ST_ADDR) begin
			addr0_q  <= base;
			row_q    <= row;
			w_q[0]   <= 33'(34'(gx) * 34'(gy));
			w_q[1]   <= 33'(34'(fx_q) * 34'(gy));
			w_q[2]   <= 33'(34'(gx) * 34'(fy_q));
			w_q[3]   <= 33'(34'(fx_q) * 34'(fy_q));
			fxgx_q   <= 32'(34'(fx_q) * 34'(gx));
			fygy_q   <= 32'(34'(fy_q) * 34'(gy));
			acc_v_q  <= '0;
			acc_xx_q <= '0;
			acc_yy_q <= '0;
		end
		if (state_q == ST_READ) begin
			vld_q  <= rd_ok;
			widx_q <= cnt_q[1:0];
			cx_q   <= 31'((64'(half_sq_x_q) * 64'(fxgx_q)) >> 32);
			cy_q   <= 31'((64'(half_sq_y_q) * 64'(fygy_q)) >> 32);
			// data of the previous slot's read is on the ram outputs now
			if (cnt_q != 3'd0) begin
				acc_v_q  <= acc_v_q + tv;
				acc_xx_q <= acc_xx_q + txx;
				acc_yy_q <= acc_yy_q + tyy;
			end
		end
		if (state_q == ST_RND) begin
			f_q   <= f_now;
			fxx_q <= rnd32(acc_xx_q);
			fyy_q <= rnd32(acc_yy_q);
			result_q.interp_value <= f_now;
			result_q.outside_grid <= 1'b0;
			result_q.saturated    <= 1'b0;
		end
		if (state_q == ST_QMUL) begin
			pxx_q <= $signed({1'b0, cx_q}) * fxx_q;
			pyy_q <= $signed({1'b0, cy_q}) * fyy_q;
		end
		if (state_q == ST_FIN) begin
			result_q.interp_value <= fin_val;
			result_q.outside_grid <= 1'b0;
			result_q.saturated    <= fin_sat;
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

	// a result word always ends a query run
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result word without a running query");

	// tables are only written while no query reads them
	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(we_v || we_xx || we_yy) |-> !busy)
		else $error("table write during a query");

	// an off grid point gives a clean zero word
	a_outside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.outside_grid) |->
			(result.interp_value == 32'sd0 && !result.saturated))
		else $error("off grid result not zero");

	// a convex blend never clips
	a_lin_nosat: assert property (@(posedge clk) disable iff (!arst_n)
		(done && op_q == OP_LIN) |-> !result.saturated)
		else $error("linear query flagged as clipped");

	// corner slot counter stays within the four reads plus drain
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> (cnt_q <= 3'd4))
		else $error("corner counter out of range");

endmodule

// File: rtl/core/ugi_ram.sv
// generic single write, single read ram with registered read data
module ugi_ram #(
	parameter int unsigned W = 32,
	parameter int unsigned D = 4096
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
